>>> src/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared widths, thresholds, result kinds, register map and structure types.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int unsigned CODE_W = 21;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned ADDR_W = 2;
  localparam int unsigned DATA_W = 32;

  localparam logic [LIMIT_W-1:0] MAX_CHAR_LIMIT = 16'd65535;

  localparam logic [7:0] LEAD_ONE_END = 8'h80;
  localparam logic [7:0] LEAD_TWO_END = 8'he0;
  localparam logic [7:0] LEAD_THREE_END = 8'hf0;
  localparam logic [7:0] LEAD_FOUR_END = 8'hf8;
  localparam logic [7:0] CONT_MAX = 8'hbf;
  localparam logic [7:0] NUL_BYTE = 8'h00;

  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TERM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_NARROW_MODE = 2'd0;

  typedef struct packed {
    logic [7:0]         in_byte;
    logic               first_of_string;
    logic [LIMIT_W-1:0] char_limit;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [KIND_W-1:0] kind;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0]         bytes_left;
    logic [CODE_W-1:0]  code_accum;
    logic [LIMIT_W-1:0] chars_done;
    logic [LIMIT_W-1:0] limit_held;
    logic               stopped;
  } dec_state_t;

endpackage

>>> src/utf8sd_in_if.sv
// ----------------------------------------------------------------------------
// UTF-8 byte channel
// Valid/ready channel carrying one byte of a UTF-8 string per transaction.
// ----------------------------------------------------------------------------
interface utf8sd_in_if import utf8sd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [7:0]         in_byte;
  logic               first_of_string;
  logic [LIMIT_W-1:0] char_limit;

  modport source (output valid, output in_byte, output first_of_string,
                  output char_limit, input ready);
  modport sink (input valid, input in_byte, input first_of_string,
                input char_limit, output ready);
endinterface

>>> src/utf8sd_out_if.sv
// ----------------------------------------------------------------------------
// Code point channel
// Valid/ready channel carrying one decoded result per transaction.
// ----------------------------------------------------------------------------
interface utf8sd_out_if import utf8sd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] out_code;
  logic [KIND_W-1:0] out_kind;
  logic              out_last;

  modport source (output valid, output out_code, output out_kind,
                  output out_last, input ready);
  modport sink (input valid, input out_code, input out_kind,
                input out_last, output ready);
endinterface

>>> src/utf8_stream_decoder_top.sv
// A byte is registered in the input register, decoded combinationally there
// and its result is registered in the output register, which presents it.
// Throughput: one byte per cycle while the output register is free; a byte with
// a result waits in the input register otherwise; bytes without one never stall.
// Reset (rst, synchronous, active high) clears narrow mode, empties both
// registers and leaves the decoder waiting for the first byte of a string.
// ----------------------------------------------------------------------------
// UTF-8 stream decoder top level
// Input register, decode core, output register and APB configuration port.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top import utf8sd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  utf8sd_in_if.sink         byte_stream,
  utf8sd_out_if.source      code_stream,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic    narrow_mode;
  logic    s1_valid;
  item_t   s1_item;
  logic    out_valid;
  result_t out_res;
  result_t res;
  logic    out_free;
  logic    step;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NARROW_MODE) ? {31'd0, narrow_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == ADDR_NARROW_MODE)) begin
      narrow_mode <= pwdata[0];
    end
  end

  assign out_free = !out_valid || code_stream.ready;
  assign step = s1_valid && (!res.valid || out_free);
  assign byte_stream.ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_stream.valid && byte_stream.ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      s1_item.in_byte <= byte_stream.in_byte;
      s1_item.first_of_string <= byte_stream.first_of_string;
      s1_item.char_limit <= byte_stream.char_limit;
    end
  end

  utf8sd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (s1_item),
    .narrow_mode (narrow_mode),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res.valid) begin
      out_res <= res;
    end
  end

  assign code_stream.valid = out_valid;
  assign code_stream.out_code = out_res.code;
  assign code_stream.out_kind = out_res.kind;
  assign code_stream.out_last = out_res.last;

`ifndef SYNTHESIS
  a_noncharacter_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.kind != KIND_CHAR)) |->
    ((out_res.code == '0) && out_res.last))
    else $error("Terminator or error result with nonzero code or not last.");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !step) |=> s1_valid)
    else $error("Input register dropped a byte that was not decoded.");

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !code_stream.ready) |=> (out_valid && $stable(out_res)))
    else $error("Output transaction changed while it was stalled.");
`endif

endmodule

>>> src/utf8sd_core.sv
// ----------------------------------------------------------------------------
// UTF-8 decode core
// Holds the per-string decoder state and decodes one byte per step.
// ----------------------------------------------------------------------------
module utf8sd_core import utf8sd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  logic    narrow_mode,
  output result_t res
);

  dec_state_t         state;
  dec_state_t         state_next;
  dec_state_t         cur;
  logic [LIMIT_W-1:0] limit_capped;
  logic [LIMIT_W-1:0] chars_inc;
  logic [CODE_W-1:0]  accum_shift;
  logic [7:0]         b;

  assign b = item.in_byte;
  assign limit_capped = ({1'b0, item.char_limit} > {1'b0, MAX_CHAR_LIMIT}) ?
                        MAX_CHAR_LIMIT : item.char_limit;

  always_comb begin
    cur = state;
    if (item.first_of_string) begin
      cur.limit_held = limit_capped;
      cur.chars_done = '0;
      cur.bytes_left = 2'd0;
      cur.code_accum = '0;
      cur.stopped = 1'b0;
    end
  end

  assign chars_inc = cur.chars_done + 16'd1;
  assign accum_shift = {cur.code_accum[CODE_W-7:0], b[5:0]};

  always_comb begin
    state_next = cur;
    res = '0;
    if (item.first_of_string && (limit_capped == '0)) begin
      res.valid = 1'b1;
      res.kind = KIND_TERM;
      res.last = 1'b1;
      state_next.stopped = 1'b1;
    end else if (!cur.stopped) begin
      if (cur.bytes_left != 2'd0) begin
        if (b > CONT_MAX) begin
          state_next.bytes_left = 2'd0;
          state_next.stopped = 1'b1;
          res.valid = 1'b1;
          res.kind = KIND_ERROR;
          res.last = 1'b1;
        end else begin
          state_next.code_accum = accum_shift;
          state_next.bytes_left = cur.bytes_left - 2'd1;
          if (cur.bytes_left == 2'd1) begin
            state_next.chars_done = chars_inc;
            res.valid = 1'b1;
            res.kind = KIND_CHAR;
            res.code = accum_shift;
            res.last = (chars_inc >= cur.limit_held);
            state_next.stopped = (chars_inc >= cur.limit_held);
          end
        end
      end else if (b == NUL_BYTE) begin
        state_next.stopped = 1'b1;
        res.valid = 1'b1;
        res.kind = KIND_TERM;
        res.last = 1'b1;
      end else if (b < LEAD_ONE_END) begin
        state_next.chars_done = chars_inc;
        res.valid = 1'b1;
        res.kind = KIND_CHAR;
        res.code = {14'd0, b[6:0]};
        res.last = (chars_inc >= cur.limit_held);
        state_next.stopped = (chars_inc >= cur.limit_held);
      end else if (b < LEAD_TWO_END) begin
        state_next.code_accum = {16'd0, b[4:0]};
        state_next.bytes_left = 2'd1;
      end else if ((b < LEAD_FOUR_END) && !narrow_mode) begin
        if (b < LEAD_THREE_END) begin
          state_next.code_accum = {17'd0, b[3:0]};
          state_next.bytes_left = 2'd2;
        end else begin
          state_next.code_accum = {18'd0, b[2:0]};
          state_next.bytes_left = 2'd3;
        end
      end else begin
        state_next.stopped = 1'b1;
        res.valid = 1'b1;
        res.kind = KIND_ERROR;
        res.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.bytes_left <= 2'd0;
      state.code_accum <= '0;
      state.chars_done <= '0;
      state.limit_held <= '0;
      state.stopped <= 1'b1;
    end else if (step) begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_stopped_no_partial: assert property (@(posedge clk) disable iff (rst)
    state.stopped |-> (state.bytes_left == 2'd0))
    else $error("Decoder stopped with a character still in progress.");

  a_stopped_silent: assert property (@(posedge clk) disable iff (rst)
    (step && state.stopped && !item.first_of_string) |-> !res.valid)
    else $error("Result produced while the string was stopped.");

  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && res.last) |=> state.stopped)
    else $error("Final result did not stop the string.");
`endif

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Drives byte strings through the decoder and checks every decoded result
// against a cycle-free prediction of the decoder. A short directed section
// covers the lead byte classes, the limits, the terminator and the error
// cases. Random strings then run in phases with different narrow mode
// settings and different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_top import utf8sd_pkg::*; ;

  class decode_scoreboard;
    bit                 narrow;
    logic [1:0]         pending_cont;
    logic [CODE_W-1:0]  partial_code;
    logic [LIMIT_W-1:0] char_count;
    logic [LIMIT_W-1:0] char_cap;
    bit                 halted;
    result_t            expected_q[$];
    int unsigned        mismatches;
    int unsigned        live_bytes;

    function new();
      narrow = 1'b0;
      pending_cont = '0;
      partial_code = '0;
      char_count = '0;
      char_cap = '0;
      halted = 1'b1;
      mismatches = 0;
      live_bytes = 0;
    endfunction

    function void push_result(logic [CODE_W-1:0] code, logic [KIND_W-1:0] kind,
                              logic last);
      result_t r;
      r.valid = 1'b1;
      r.code = code;
      r.kind = kind;
      r.last = last;
      if (last) begin
        halted = 1'b1;
      end
      expected_q.push_back(r);
    endfunction

    function void add_char(logic [CODE_W-1:0] code);
      char_count = char_count + 1'b1;
      push_result(code, KIND_CHAR, char_count >= char_cap);
    endfunction

    function void note_byte(item_t it);
      logic [7:0] b;
      b = it.in_byte;
      live_bytes++;
      if (!it.first_of_string && halted) begin
        return;
      end
      if (it.first_of_string) begin
        char_cap = (it.char_limit > MAX_CHAR_LIMIT) ? MAX_CHAR_LIMIT :
                   it.char_limit;
        char_count = '0;
        pending_cont = '0;
        partial_code = '0;
        halted = 1'b0;
        if (char_cap == '0) begin
          push_result('0, KIND_TERM, 1'b1);
          return;
        end
      end
      if (pending_cont != 2'd0) begin
        if (b > CONT_MAX) begin
          pending_cont = '0;
          push_result('0, KIND_ERROR, 1'b1);
          return;
        end
        partial_code = {partial_code[CODE_W-7:0], b[5:0]};
        pending_cont = pending_cont - 1'b1;
        if (pending_cont == 2'd0) begin
          add_char(partial_code);
        end
        return;
      end
      if (b == NUL_BYTE) begin
        push_result('0, KIND_TERM, 1'b1);
      end else if (b < LEAD_ONE_END) begin
        add_char(CODE_W'(b[6:0]));
      end else if (b < LEAD_TWO_END) begin
        partial_code = CODE_W'(b[4:0]);
        pending_cont = 2'd1;
      end else if (b < LEAD_FOUR_END && !narrow) begin
        if (b < LEAD_THREE_END) begin
          partial_code = CODE_W'(b[3:0]);
          pending_cont = 2'd2;
        end else begin
          partial_code = CODE_W'(b[2:0]);
          pending_cont = 2'd3;
        end
      end else begin
        push_result('0, KIND_ERROR, 1'b1);
      end
    endfunction

    function void check_result(logic [CODE_W-1:0] code, logic [KIND_W-1:0] kind,
                               logic last);
      result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: code %h kind %0d last %0b", code, kind, last);
        end
        return;
      end
      e = expected_q.pop_front();
      if (e.code !== code || e.kind !== kind || e.last !== last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected code %h kind %0d last %0b, %s",
                   e.code, e.kind, e.last,
                   $sformatf("got code %h kind %0d last %0b", code, kind, last));
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  utf8sd_in_if  byte_if();
  utf8sd_out_if code_if();

  utf8_stream_decoder_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_if),
    .code_stream (code_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  decode_scoreboard   sb = new();
  int unsigned        src_idle_pct = 0;
  int unsigned        sink_stall_pct = 0;
  bit                 start_pending = 1'b0;
  logic [LIMIT_W-1:0] start_limit = '0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    code_if.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_if.valid && byte_if.ready) begin
        sb.note_byte(item_t'{byte_if.in_byte, byte_if.first_of_string,
                             byte_if.char_limit});
      end
      if (code_if.valid && code_if.ready) begin
        sb.check_result(code_if.out_code, code_if.out_kind, code_if.out_last);
      end
    end
  end

  task automatic send_byte(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_if.valid = 1'b0;
      @(negedge clk);
    end
    byte_if.valid = 1'b1;
    byte_if.in_byte = it.in_byte;
    byte_if.first_of_string = it.first_of_string;
    byte_if.char_limit = it.char_limit;
    @(posedge clk);
    while (!byte_if.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic put_byte(input logic [7:0] b);
    item_t it;
    it.in_byte = b;
    it.first_of_string = start_pending;
    it.char_limit = start_pending ? start_limit : LIMIT_W'($urandom());
    start_pending = 1'b0;
    send_byte(it);
  endtask

  task automatic put_cont();
    if ($urandom_range(99) < 90) begin
      put_byte(8'($urandom_range(8'hbf, 8'h80)));
    end else begin
      put_byte(8'($urandom_range(8'h7f, 8'h00)));
    end
  endtask

  task automatic send_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) begin
      put_byte(8'($urandom_range(8'h7f, 8'h01)));
    end else if (r < (sb.narrow ? 92 : 65)) begin
      put_byte(8'($urandom_range(8'hdf, 8'h80)));
      put_cont();
    end else if (r < (sb.narrow ? 96 : 85)) begin
      put_byte(8'($urandom_range(8'hef, 8'he0)));
      repeat (2) put_cont();
    end else begin
      put_byte(8'($urandom_range(8'hf7, 8'hf0)));
      repeat (3) put_cont();
    end
  endtask

  task automatic send_string();
    int unsigned r;
    int unsigned nchars;
    r = $urandom_range(99);
    if (r < 5) begin
      start_limit = '0;
    end else if (r < 10) begin
      start_limit = MAX_CHAR_LIMIT;
    end else if (r < 20) begin
      start_limit = LIMIT_W'($urandom());
    end else begin
      start_limit = LIMIT_W'($urandom_range(10, 1));
    end
    start_pending = 1'b1;
    nchars = $urandom_range(12, 1);
    repeat (nchars) begin
      r = $urandom_range(99);
      if (r < 88) begin
        send_char();
      end else if (r < 90) begin
        put_byte(NUL_BYTE);
      end else if (r < 92) begin
        put_byte(8'($urandom_range(8'hff, 8'hf8)));
      end else if (r < 95) begin
        put_byte(8'($urandom_range(8'hdf, 8'hc0)));
        put_byte(8'($urandom_range(8'hff, 8'hc0)));
      end else if (r < 97) begin
        put_byte(8'($urandom_range(8'hef, 8'he0)));
        start_pending = 1'b1;
        start_limit = LIMIT_W'($urandom_range(10, 1));
      end else begin
        put_byte(8'($urandom_range(8'hff, 8'h00)));
      end
    end
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == ADDR_NARROW_MODE) begin
      sb.narrow = data[0];
    end
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int unsigned src_pcts[4];
    int unsigned sink_pcts[4];
    int unsigned start_count;
    src_pcts = '{0, 61, 0, 34};
    sink_pcts = '{0, 0, 61, 34};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_if.valid = 1'b0;
    byte_if.in_byte = '0;
    byte_if.first_of_string = 1'b0;
    byte_if.char_limit = '0;
    code_if.ready = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(ADDR_NARROW_MODE, 32'd0);
    send_byte(item_t'{8'h41, 1'b0, 16'h1234});
    send_byte(item_t'{8'hff, 1'b1, 16'h0000});
    send_byte(item_t'{8'h41, 1'b0, 16'hffff});
    send_byte(item_t'{8'h00, 1'b1, 16'hffff});
    send_byte(item_t'{8'h7f, 1'b1, 16'hffff});
    send_byte(item_t'{8'h01, 1'b0, 16'h0000});
    send_byte(item_t'{8'hc3, 1'b0, 16'haaaa});
    send_byte(item_t'{8'ha9, 1'b0, 16'h5555});
    send_byte(item_t'{8'h80, 1'b0, 16'h0000});
    send_byte(item_t'{8'hbf, 1'b0, 16'hffff});
    send_byte(item_t'{8'hc2, 1'b0, 16'h0000});
    send_byte(item_t'{8'h00, 1'b0, 16'h0000});
    send_byte(item_t'{8'he2, 1'b0, 16'h0000});
    send_byte(item_t'{8'h82, 1'b0, 16'h0000});
    send_byte(item_t'{8'hac, 1'b0, 16'h0000});
    send_byte(item_t'{8'hf7, 1'b0, 16'h0000});
    send_byte(item_t'{8'hbf, 1'b0, 16'h0000});
    send_byte(item_t'{8'hbf, 1'b0, 16'h0000});
    send_byte(item_t'{8'hbf, 1'b0, 16'h0000});
    send_byte(item_t'{8'he2, 1'b0, 16'h0000});
    send_byte(item_t'{8'h41, 1'b1, 16'h0002});
    send_byte(item_t'{8'h42, 1'b0, 16'h0000});
    send_byte(item_t'{8'h43, 1'b0, 16'h0000});
    send_byte(item_t'{8'hc3, 1'b1, 16'h0003});
    send_byte(item_t'{8'hc0, 1'b0, 16'h0000});
    send_byte(item_t'{8'hf8, 1'b1, 16'h0005});
    byte_if.valid = 1'b0;
    wait_drained();

    write_reg(ADDR_NARROW_MODE, 32'd1);
    send_byte(item_t'{8'he0, 1'b1, 16'h0005});
    send_byte(item_t'{8'hdf, 1'b1, 16'h0005});
    send_byte(item_t'{8'hbf, 1'b0, 16'h0000});
    send_byte(item_t'{8'hf0, 1'b0, 16'h0000});
    byte_if.valid = 1'b0;

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_reg(ADDR_NARROW_MODE, DATA_W'(p % 2));
      src_idle_pct = src_pcts[p];
      sink_stall_pct = sink_pcts[p];
      start_count = sb.live_bytes;
      while (sb.live_bytes - start_count < 230) begin
        send_string();
      end
      byte_if.valid = 1'b0;
    end

    while (sb.expected_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (6) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
